FILE: rtl/mprm_pkg.sv
// mprm_pkg: shared types, constants and the response string table
// used by mprm_lane and multi_pattern_response_matcher
`timescale 1ns / 1ps
`default_nettype none

package mprm_pkg;

    localparam int TABLE_SIZE = 17;
    localparam int TEXT_MAX   = 17;
    localparam int POS_W      = 5;
    localparam int INDEX_W    = 5;
    localparam int COUNT_W    = 11;
    localparam int MASK_W     = 17;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_INDEX_W = 1;

    typedef enum logic [1:0] {
        STATUS_MATCH   = 2'd0,
        STATUS_TIMEOUT = 2'd1,
        STATUS_FULL    = 2'd2
    } status_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_ACCEPT_MASK = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_LIMIT  = 1'b1;

    localparam logic [7:0] CHAR_CR = 8'h0d;
    localparam logic [7:0] CHAR_LF = 8'h0a;

    // strings right-justified, first character in the highest used byte
    localparam logic [8*TEXT_MAX-1:0] PATTERN_STR [TABLE_SIZE] = '{
        "SEND OK\015\012",
        "SEND FAIL\015\012",
        "ERROR\015\012",
        "Unlink\015\012",
        "Linked\015\012",
        ",CLOSED\015\012",
        ",CONNECT\015\012",
        "WIFI GOT IP\015\012",
        "WIFI CONNECTED\015\012",
        "WIFI DISCONNECT\015\012",
        "ready\015\012",
        "+IPD,",
        "OK\015\012",
        "+CIPSTA:ip:",
        "+CIPSTA:gateway:",
        "+CIPSTA:netmask:",
        "\015\012"
    };

    localparam logic [POS_W-1:0] PATTERN_LEN [TABLE_SIZE] = '{
        5'd9, 5'd11, 5'd7, 5'd8, 5'd8, 5'd9, 5'd10, 5'd13, 5'd16,
        5'd17, 5'd7, 5'd5, 5'd4, 5'd11, 5'd16, 5'd16, 5'd2
    };

    typedef struct packed {
        logic step;
        logic clear;
    } mprm_lane_ctl_t;

    function automatic logic [7:0] pat_char(input logic [INDEX_W-1:0] idx,
                                            input logic [POS_W-1:0] pos);
        logic [8*TEXT_MAX-1:0] s;
        logic [POS_W-1:0]      len;
        logic [POS_W-1:0]      sh;
        s   = PATTERN_STR[idx];
        len = PATTERN_LEN[idx];
        sh  = len - pos - 5'd1;
        if (pos >= len)
        begin
            return 8'h00;
        end
        return s[{sh, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mprm_in_if.sv
// mprm_in_if: input item channel, valid/ready with kind and data byte
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface mprm_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink (input valid, input kind, input data_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/mprm_out_if.sv
// mprm_out_if: result item channel, valid/ready with status, index, length
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface mprm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [4:0]  pattern_index;
    logic [10:0] line_length;

    modport source (output valid, output status, output pattern_index,
                    output line_length, input ready);
    modport sink (input valid, input status, input pattern_index,
                  input line_length, output ready);
endinterface

`default_nettype wire

FILE: rtl/mprm_lane.sv
// mprm_lane: match position register and compare for one table pattern
// depends on mprm_pkg
`timescale 1ns / 1ps
`default_nettype none

module mprm_lane
    import mprm_pkg::*;
#(
    parameter int PAT_ID = 0
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mprm_lane_ctl_t ctl,
    input  wire logic [7:0]     data_byte,
    output logic                hit
);

    localparam logic [INDEX_W-1:0] ID  = INDEX_W'(PAT_ID);
    localparam logic [POS_W-1:0]   LEN = PATTERN_LEN[PAT_ID];

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] base;
    logic [POS_W-1:0] step_pos;
    logic             cur_ok;
    logic             adv;

    always_comb
    begin
        cur_ok   = (pos_reg < LEN) && (pat_char(ID, pos_reg) == data_byte);
        base     = cur_ok ? pos_reg : '0;
        adv      = (data_byte != 8'h00) && (pat_char(ID, base) == data_byte);
        step_pos = base + 5'd1;
        hit      = adv && (step_pos == LEN);
        if (ctl.clear)
        begin
            pos_next = '0;
        end
        else if (ctl.step)
        begin
            pos_next = (adv && !hit) ? step_pos : '0;
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/multi_pattern_response_matcher.sv
// the item that ends a search passes the input register; its result is then held in the output register
// throughput: one item per cycle; the output register holds a result while the next
// item is registered, so only a stalled result with a full input register stops input
// reset: match positions, line count and previous byte zero, accept_mask 60389,
// line_limit 1600, both channel stages empty
// depends on mprm_pkg, mprm_in_if, mprm_out_if, mprm_lane
`timescale 1ns / 1ps
`default_nettype none

module multi_pattern_response_matcher
    import mprm_pkg::*;
#(
    parameter int PATTERN_COUNT = 17,
    parameter int LINE_CAPACITY = 2047
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    mprm_in_if.sink                     rx,
    mprm_out_if.source                  result,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int ACTIVE = (PATTERN_COUNT < TABLE_SIZE) ? PATTERN_COUNT : TABLE_SIZE;
    localparam logic [16:0] CAP = 17'(LINE_CAPACITY);

    logic [MASK_W-1:0]  accept_mask_reg;
    logic [COUNT_W-1:0] line_limit_reg;

    logic               in_v_reg;
    logic               kind_reg;
    logic [7:0]         byte_reg;

    logic               out_v_reg;
    logic               out_v_next;
    status_t            status_reg;
    logic [INDEX_W-1:0] index_reg;
    logic [COUNT_W-1:0] len_reg;

    logic [COUNT_W-1:0] line_count_reg;
    logic [COUNT_W-1:0] line_count_next;
    logic [7:0]         prev_reg;
    logic [7:0]         prev_next;

    logic               advance;
    logic               full;
    logic               matched;
    logic               emit;
    logic [16:0]        limit_ext;
    logic [16:0]        eff_limit;
    logic [COUNT_W-1:0] count_inc;
    logic [ACTIVE-1:0]  hits;
    logic [ACTIVE-1:0]  acc;
    logic [INDEX_W-1:0] hit_index;
    status_t            emit_status;
    logic [COUNT_W-1:0] emit_len;
    mprm_lane_ctl_t     lane_ctl;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accept_mask_reg <= 17'd60389;
            line_limit_reg  <= 11'd1600;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ACCEPT_MASK: accept_mask_reg <= cfg_data[MASK_W-1:0];
                CFG_LINE_LIMIT:  line_limit_reg  <= cfg_data[COUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    assign advance  = in_v_reg && (!out_v_reg || result.ready);
    assign rx.ready = !in_v_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_v_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            kind_reg <= rx.kind;
            byte_reg <= rx.data_byte;
        end
    end

    // line limit check
    always_comb
    begin
        limit_ext = {6'b0, line_limit_reg};
        eff_limit = (limit_ext > CAP) ? CAP : limit_ext;
        full      = !kind_reg && ({6'b0, line_count_reg} >= eff_limit);
        count_inc = line_count_reg + 11'd1;
    end

    assign lane_ctl.step  = advance && !kind_reg && !full;
    assign lane_ctl.clear = emit;

    genvar g;
    generate
        for (g = 0; g < ACTIVE; g++)
        begin : g_lane
            mprm_lane #(
                .PAT_ID (g)
            ) u_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (lane_ctl),
                .data_byte (byte_reg),
                .hit       (hits[g])
            );
        end
    endgenerate

    // lowest accepted table entry wins
    always_comb
    begin
        acc       = hits & accept_mask_reg[ACTIVE-1:0];
        hit_index = '0;
        for (int i = ACTIVE - 1; i >= 0; i--)
        begin
            if (acc[i])
            begin
                hit_index = INDEX_W'(i);
            end
        end
        matched = lane_ctl.step && (|acc);
        emit    = advance && (kind_reg || full || matched);
    end

    always_comb
    begin
        priority if (kind_reg)
        begin
            emit_status = STATUS_TIMEOUT;
            emit_len    = line_count_reg;
        end
        else if (full)
        begin
            emit_status = STATUS_FULL;
            emit_len    = line_count_reg;
        end
        else
        begin
            emit_status = STATUS_MATCH;
            emit_len    = count_inc;
        end
    end

    // line state
    always_comb
    begin
        line_count_next = line_count_reg;
        prev_next       = prev_reg;
        if (emit)
        begin
            line_count_next = '0;
            prev_next       = '0;
        end
        else if (lane_ctl.step)
        begin
            prev_next = byte_reg;
            if (count_inc >= 11'd2 && prev_reg == CHAR_CR && byte_reg == CHAR_LF)
            begin
                line_count_next = '0;
            end
            else
            begin
                line_count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg <= '0;
            prev_reg       <= '0;
        end
        else
        begin
            line_count_reg <= line_count_next;
            prev_reg       <= prev_next;
        end
    end

    // result register
    always_comb
    begin
        if (emit)
        begin
            out_v_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_v_next = 1'b0;
        end
        else
        begin
            out_v_next = out_v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status_reg <= emit_status;
            index_reg  <= (emit_status == STATUS_MATCH) ? hit_index : '0;
            len_reg    <= emit_len;
        end
    end

    assign result.valid         = out_v_reg;
    assign result.status        = status_reg;
    assign result.pattern_index = index_reg;
    assign result.line_length   = len_reg;

endmodule

`default_nettype wire

FILE: verif/multi_pattern_response_matcher_tb.sv
// testbench for multi_pattern_response_matcher: directed and random byte streams,
// a scoreboard class predicts every search result and checks the result channel
// depends on mprm_pkg, mprm_in_if, mprm_out_if and the rtl top level
`timescale 1ns / 1ps

module multi_pattern_response_matcher_tb;
    import mprm_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 80;
    localparam int SETTLE_CYCLES = 6;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        status_t          status;
        logic [INDEX_W-1:0] pattern_index;
        logic [COUNT_W-1:0] line_length;
    } search_report_t;

    class match_scoreboard;
        string            patterns[TABLE_SIZE];
        logic [MASK_W-1:0] accept_mask;
        logic [COUNT_W-1:0] line_limit;
        logic [POS_W-1:0]  position[TABLE_SIZE];
        logic [COUNT_W-1:0] line_count;
        logic [7:0]        previous_byte;
        search_report_t    pending_reports[$];
        int                failures;

        function new();
            patterns = '{
                "SEND OK\015\012", "SEND FAIL\015\012", "ERROR\015\012",
                "Unlink\015\012", "Linked\015\012", ",CLOSED\015\012",
                ",CONNECT\015\012", "WIFI GOT IP\015\012",
                "WIFI CONNECTED\015\012", "WIFI DISCONNECT\015\012",
                "ready\015\012", "+IPD,", "OK\015\012", "+CIPSTA:ip:",
                "+CIPSTA:gateway:", "+CIPSTA:netmask:", "\015\012"
            };
            accept_mask = 17'd60389;
            line_limit  = 11'd1600;
            failures    = 0;
            clear_search();
        endfunction

        function void clear_search();
            foreach (position[i])
            begin
                position[i] = '0;
            end
            line_count    = '0;
            previous_byte = '0;
        endfunction

        function void queue_report(status_t status, int index);
            search_report_t r;
            r.status        = status;
            r.pattern_index = index[INDEX_W-1:0];
            r.line_length   = line_count;
            pending_reports.push_back(r);
            clear_search();
        endfunction

        function void note_item(logic kind, logic [7:0] data_byte);
            int len;
            int p;
            if (kind)
            begin
                queue_report(STATUS_TIMEOUT, 0);
                return;
            end
            if (line_count >= line_limit)
            begin
                queue_report(STATUS_FULL, 0);
                return;
            end
            line_count++;
            for (int x = 0; x < TABLE_SIZE; x++)
            begin
                len = patterns[x].len();
                p   = position[x];
                if (p >= len || patterns[x][p] != data_byte)
                begin
                    p = 0;
                end
                if (p < len && data_byte != 8'h00 && patterns[x][p] == data_byte)
                begin
                    p++;
                    if (p >= len)
                    begin
                        if (accept_mask[x])
                        begin
                            queue_report(STATUS_MATCH, x);
                            return;
                        end
                        p = 0;
                    end
                end
                position[x] = p[POS_W-1:0];
            end
            if (line_count >= 2 && previous_byte == CHAR_CR && data_byte == CHAR_LF)
            begin
                line_count = '0;
            end
            previous_byte = data_byte;
        endfunction

        function void check_report(status_t status, logic [INDEX_W-1:0] pattern_index,
                                   logic [COUNT_W-1:0] line_length);
            search_report_t e;
            if (pending_reports.size() == 0)
            begin
                if (failures < REPORT_MAX)
                begin
                    $display("unexpected result: status %0d index %0d length %0d",
                             status, pattern_index, line_length);
                end
                failures++;
                return;
            end
            e = pending_reports.pop_front();
            if (e.status != status || e.pattern_index != pattern_index
                || e.line_length != line_length)
            begin
                if (failures < REPORT_MAX)
                begin
                    $display({"result mismatch: expected status %0d index %0d ",
                              "length %0d, got status %0d index %0d length %0d"},
                             e.status, e.pattern_index, e.line_length,
                             status, pattern_index, line_length);
                end
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic idling;
    logic hold_active;
    int   cycle_count;
    int   items_sent;

    match_scoreboard sb;

    mprm_in_if  rx_if ();
    mprm_out_if res_if ();

    multi_pattern_response_matcher DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_if),
        .result    (res_if),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin : watchdog
        while (cycle_count <= CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        $display("Regression FAIL");
        $finish;
    end

    // result side: check accepted items, random stalls and the long hold-off
    initial
    begin : receiver
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready)
            begin
                sb.check_report(status_t'(res_if.status), res_if.pattern_index,
                                res_if.line_length);
            end
            if (stall == 0 && idling && $urandom_range(0, 4) == 0)
            begin
                stall = $urandom_range(1, 9);
            end
            if (hold_active || stall > 0)
            begin
                res_if.ready <= 1'b0;
                if (stall > 0)
                begin
                    stall--;
                end
            end
            else
            begin
                res_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic kind, input logic [7:0] data_byte);
        int gap;
        if (idling && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_if.valid     <= 1'b1;
        rx_if.kind      <= kind;
        rx_if.data_byte <= data_byte;
        @(posedge clk);
        while (!rx_if.ready)
        begin
            @(posedge clk);
        end
        sb.note_item(kind, data_byte);
        items_sent++;
    endtask

    task automatic send_text(input string s, input int n);
        for (int i = 0; i < n; i++)
        begin
            send_item(1'b0, s[i]);
        end
    endtask

    task automatic wait_drained();
        rx_if.valid <= 1'b0;
        while (sb.pending_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [MASK_W-1:0] mask,
                                  input logic [COUNT_W-1:0] limit);
        cfg_write <= 1'b1;
        cfg_index <= CFG_ACCEPT_MASK;
        cfg_data  <= CFG_DATA_W'(mask);
        @(posedge clk);
        cfg_index <= CFG_LINE_LIMIT;
        cfg_data  <= CFG_DATA_W'(limit);
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.accept_mask = mask;
        sb.line_limit  = limit;
    endtask

    // mostly whole or broken responses, with line ends, timeouts and noise
    task automatic send_stream(input int quota, input logic allow_idling);
        int target;
        int choice;
        int idx;
        target = items_sent + quota;
        while (items_sent < target)
        begin
            if (allow_idling && $urandom_range(0, 7) == 0)
            begin
                idling <= 1'($urandom_range(0, 1));
            end
            choice = $urandom_range(0, 99);
            idx    = $urandom_range(0, TABLE_SIZE - 1);
            if (choice < 50)
            begin
                send_text(sb.patterns[idx], sb.patterns[idx].len());
            end
            else if (choice < 62)
            begin
                send_text(sb.patterns[idx], $urandom_range(1, sb.patterns[idx].len()));
            end
            else if (choice < 72)
            begin
                send_text("\015\012", 2);
            end
            else if (choice < 80)
            begin
                send_item(1'b1, 8'($urandom_range(0, 255)));
            end
            else
            begin
                repeat ($urandom_range(1, 5)) send_item(1'b0, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin : stimulus
        sb              = new();
        rst_n           = 1'b0;
        cfg_write       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        rx_if.valid     = 1'b0;
        rx_if.kind      = 1'b0;
        rx_if.data_byte = 8'h00;
        res_if.ready    = 1'b0;
        idling          = 1'b0;
        hold_active     = 1'b0;
        cycle_count     = 0;
        items_sent      = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: accepted entry, zero and top byte, unaccepted completion
        send_text("+IPD,", 5);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        send_text("OK\015\012", 4);
        send_text("ER", 2);
        send_item(1'b1, 8'h5A);
        wait_drained();

        // three entries completing on the same byte, then line full
        apply_settings(17'h1FFFF, 11'd2047);
        send_text("SEND OK\015\012", 9);
        wait_drained();
        apply_settings(17'h1FFFF, 11'd1);
        send_item(1'b0, "A");
        send_item(1'b0, "B");
        wait_drained();
        apply_settings(17'h00000, 11'd0);
        send_item(1'b0, "C");
        wait_drained();

        idling <= 1'b1;
        apply_settings(17'h1FFFF, 11'd2047);
        send_stream(200, 1'b1);
        wait_drained();

        apply_settings(17'h00000, 11'd12);
        send_stream(150, 1'b1);
        wait_drained();

        apply_settings(MASK_W'($urandom_range(0, 17'h1FFFF)),
                       COUNT_W'($urandom_range(1, 40)));
        send_stream(200, 1'b1);
        wait_drained();

        // long receiver hold-off while timeouts keep coming
        apply_settings(17'd60389, 11'd1600);
        fork
            begin
                hold_active <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active <= 1'b0;
            end
        join_none
        repeat (12) send_item(1'b1, 8'($urandom_range(0, 255)));
        send_stream(200, 1'b1);
        wait_drained();

        apply_settings(MASK_W'($urandom_range(0, 17'h1FFFF)),
                       COUNT_W'($urandom_range(300, 2047)));
        send_stream(200, 1'b1);
        wait_drained();

        idling <= 1'b0;
        apply_settings(MASK_W'($urandom_range(0, 17'h1FFFF)), 11'd30);
        send_stream(200, 1'b0);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending_reports.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
